// File: rtl/csr_edge_lookup_defines.svh
// Assertion macros for the graph edge lookup block.
// Used by the top level; needs a clk and rst in the enclosing module.
`ifndef CSR_EDGE_LOOKUP_DEFINES_SVH
`define CSR_EDGE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define CEL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cel_pkg.sv
// Shared types and constants for the graph edge lookup block.
// No dependencies.
`default_nettype none
package cel_pkg;

  localparam int unsigned RUN_W  = 13;
  localparam int unsigned NODE_W = 10;
  localparam int unsigned TAG_W  = 12;

  localparam logic [1:0] OP_ROW   = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_LO,
    S_ROW_HI,
    S_RANGE,
    S_CMP,
    S_FINAL,
    S_PUT
  } state_t;

  typedef struct packed {
    logic             empty;
    logic             more;
    logic [RUN_W-1:0] mid;
  } step_t;

endpackage
`default_nettype wire

// File: rtl/cel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cel_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/cel_step.sv
// Shared search step unit: midpoint of a run and its empty / more flags.
// Depends on cel_pkg.
`default_nettype none
module cel_step (
  input  wire logic [cel_pkg::RUN_W-1:0] lo,
  input  wire logic [cel_pkg::RUN_W-1:0] hi,
  output cel_pkg::step_t                 step
);

  logic [cel_pkg::RUN_W:0] lo_inc;
  logic [cel_pkg::RUN_W-1:0] span;

  always_comb begin
    lo_inc     = {1'b0, lo} + {{cel_pkg::RUN_W{1'b0}}, 1'b1};
    span       = hi - lo;
    step.empty = (lo >= hi);
    step.more  = (lo_inc < {1'b0, hi});
    step.mid   = lo + (span >> 1);
  end

endmodule
`default_nettype wire

// File: rtl/csr_edge_lookup.sv
// Top level of the graph edge lookup block: sequencer, tables and result register.
// Depends on cel_pkg, cel_ram, cel_step and csr_edge_lookup_defines.svh.
//
// Loads write the row-start table or the edge table in the cycle they are
// accepted and free the input at once. A query holds the input stalled while
// it walks the tables through one read port each: two row-start reads, then
// one edge-table read per halving of the neighbor run, then a final compare.
// A query frees the input only once its result moves into a free output register;
// the search loop is paced by the registered edge-table read, a rejected pair
// skips the table reads and an empty run skips the search. The result sits in
// an output register, so loads are still taken while it waits to be read.
`default_nettype none
`include "csr_edge_lookup_defines.svh"
module csr_edge_lookup #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [11:0] write_index,
  input  wire logic [12:0] row_offset,
  input  wire logic [9:0]  neighbor,
  input  wire logic [11:0] tag_in,
  input  wire logic signed [10:0] node_u,
  input  wire logic signed [10:0] node_w,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [11:0]      tag_out
);

  localparam int unsigned RowDepth = MAX_NODES + 1;
  localparam int unsigned NA = $clog2(RowDepth);
  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned RW = cel_pkg::RUN_W;
  localparam int unsigned NW = cel_pkg::NODE_W;
  localparam int unsigned TW = cel_pkg::TAG_W;
  localparam int unsigned EW = NW + TW;

  cel_pkg::state_t state, state_next;

  logic [10:0]   node_count;
  logic [10:0]   bound;
  logic [NW-1:0] u, w;
  logic [RW-1:0] lo, hi, mid_q;
  logic          res_found;
  logic [TW-1:0] res_tag;

  logic          in_beat, out_free;
  logic          is_query, pair_ok;
  logic [NW-1:0] in_lo, in_hi;
  logic [10:0]   u_inc;

  logic          row_we, edge_we;
  logic [NA-1:0] row_waddr, row_raddr;
  logic [RW-1:0] row_rdata;
  logic [EA-1:0] edge_waddr, edge_raddr;
  logic [EW-1:0] edge_rdata;
  logic [NW-1:0] edge_nb;
  logic [TW-1:0] edge_tg;

  logic [RW-1:0] hi_clamp, lo_sel, hi_sel;
  cel_pkg::step_t step;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != cel_pkg::S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign is_query  = (operation == cel_pkg::OP_QUERY);
  assign edge_nb   = edge_rdata[EW-1:TW];
  assign edge_tg   = edge_rdata[TW-1:0];
  assign u_inc     = {1'b0, u} + 11'd1;

  always_comb begin
    bound = (32'(node_count) > MAX_NODES) ? 11'(MAX_NODES) : node_count;
    pair_ok = !node_u[10] && !node_w[10] &&
              ({1'b0, node_u[9:0]} < bound) && ({1'b0, node_w[9:0]} < bound) &&
              (node_u[9:0] != node_w[9:0]);
    in_lo = (node_u[9:0] < node_w[9:0]) ? node_u[9:0] : node_w[9:0];
    in_hi = (node_u[9:0] < node_w[9:0]) ? node_w[9:0] : node_u[9:0];
  end

  always_comb begin
    row_we     = in_beat && (operation == cel_pkg::OP_ROW) &&
                 (32'(write_index) <= MAX_NODES);
    row_waddr  = NA'(write_index);
    edge_we    = in_beat && (operation == cel_pkg::OP_EDGE) &&
                 (32'(write_index) < MAX_EDGES);
    edge_waddr = EA'(write_index);
  end

  cel_ram #(.WIDTH(RW), .DEPTH(RowDepth)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_offset),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  cel_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata ({neighbor, tag_in}),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  cel_step u_step (
    .lo   (lo_sel),
    .hi   (hi_sel),
    .step (step)
  );

  // datapath selects
  always_comb begin
    hi_clamp   = (32'(row_rdata) > MAX_EDGES) ? RW'(MAX_EDGES) : row_rdata;
    lo_sel     = lo;
    hi_sel     = hi;
    row_raddr  = NA'(u);
    edge_raddr = EA'(lo);
    case (state)
      cel_pkg::S_ROW_HI: begin
        row_raddr = NA'(u_inc);
      end
      cel_pkg::S_RANGE: begin
        lo_sel = lo;
        hi_sel = hi_clamp;
      end
      cel_pkg::S_CMP: begin
        if (edge_nb > w) begin
          lo_sel = lo;
          hi_sel = mid_q;
        end else begin
          lo_sel = mid_q;
          hi_sel = hi;
        end
      end
      default: begin
      end
    endcase
    edge_raddr = step.more ? EA'(step.mid) : EA'(lo_sel);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cel_pkg::S_IDLE: begin
        if (in_beat && is_query) begin
          state_next = pair_ok ? cel_pkg::S_ROW_LO : cel_pkg::S_PUT;
        end
      end
      cel_pkg::S_ROW_LO: state_next = cel_pkg::S_ROW_HI;
      cel_pkg::S_ROW_HI: state_next = cel_pkg::S_RANGE;
      cel_pkg::S_RANGE: begin
        if (step.empty) begin
          state_next = cel_pkg::S_PUT;
        end else if (step.more) begin
          state_next = cel_pkg::S_CMP;
        end else begin
          state_next = cel_pkg::S_FINAL;
        end
      end
      cel_pkg::S_CMP: begin
        if (!step.more) begin
          state_next = cel_pkg::S_FINAL;
        end
      end
      cel_pkg::S_FINAL: state_next = cel_pkg::S_PUT;
      cel_pkg::S_PUT: begin
        if (out_free) begin
          state_next = cel_pkg::S_IDLE;
        end
      end
      default: state_next = cel_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cel_pkg::S_IDLE;
      node_count <= 11'd0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (state == cel_pkg::S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cel_pkg::S_IDLE: begin
        u         <= in_lo;
        w         <= in_hi;
        res_found <= 1'b0;
        res_tag   <= '0;
      end
      cel_pkg::S_ROW_HI: begin
        lo <= row_rdata;
      end
      cel_pkg::S_RANGE, cel_pkg::S_CMP: begin
        lo    <= lo_sel;
        hi    <= hi_sel;
        mid_q <= step.mid;
      end
      cel_pkg::S_FINAL: begin
        res_found <= (edge_nb == w);
        res_tag   <= (edge_nb == w) ? edge_tg : '0;
      end
      cel_pkg::S_PUT: begin
        if (out_free) begin
          found   <= res_found;
          tag_out <= res_tag;
        end
      end
      default: begin
      end
    endcase
  end

  `CEL_ASSERT_NEXT(a_query_busy, in_beat && is_query, state != cel_pkg::S_IDLE, "query idle")
  `CEL_ASSERT_NOW(a_run_open, state == cel_pkg::S_CMP, lo < hi, "search run closed")
  `CEL_ASSERT_NOW(a_rose_from_put, $rose(out_valid), $past(state) == cel_pkg::S_PUT, "no put")
  `CEL_ASSERT_NOW(a_miss_tag_zero, out_valid && !found, tag_out == '0, "tag set on a miss")

endmodule
`default_nettype wire

// File: bench/tb_csr_edge_lookup.sv
// Self-checking testbench for csr_edge_lookup: loads small CSR graphs, runs node-pair
// lookups against an in-bench predictor under random valid/stall idling.
// Depends on cel_pkg and the csr_edge_lookup RTL only.
module tb_csr_edge_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_SLOTS  = 1024;
  localparam int EDGE_SLOTS  = 4096;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] idx;
    logic [12:0] offs;
    logic [9:0]  nb;
    logic [11:0] tag;
    logic [10:0] u;
    logic [10:0] w;
  } lookup_item_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] tag;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [11:0] write_index = '0;
  logic [12:0] row_offset = '0;
  logic [9:0] neighbor = '0;
  logic [11:0] tag_in = '0;
  logic signed [10:0] node_u = '0;
  logic signed [10:0] node_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [11:0] tag_out;

  // predictor copy of the block's tables and bound
  bit [12:0] row_tbl [0:NODE_SLOTS];
  bit [9:0]  nb_tbl  [0:EDGE_SLOTS-1];
  bit [11:0] tag_tbl [0:EDGE_SLOTS-1];
  bit        row_set [0:NODE_SLOTS];
  bit        edge_set [0:EDGE_SLOTS-1];
  logic [10:0] node_bound = '0;

  lookup_result_t pending_lookups [$];
  lookup_result_t oldest;
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  csr_edge_lookup #(
    .MAX_NODES(NODE_SLOTS),
    .MAX_EDGES(EDGE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .write_index(write_index),
    .row_offset(row_offset),
    .neighbor(neighbor),
    .tag_in(tag_in),
    .node_u(node_u),
    .node_w(node_w),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .tag_out(tag_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Returns 0 when the lookup would touch an unwritten or unsorted entry.
  function automatic bit lookup_pair(input logic [10:0] pu, input logic [10:0] pw,
                                     output lookup_result_t res);
    int bound, a, b, lo, hi, mid;
    bit ok;
    res = '0;
    ok = 1'b1;
    bound = (node_bound > NODE_SLOTS) ? NODE_SLOTS : node_bound;
    if (pu[10] || pw[10] || pu[9:0] >= bound || pw[9:0] >= bound || pu[9:0] == pw[9:0])
      return 1'b1;
    a = pu[9:0];
    b = pw[9:0];
    if (a > b) begin
      mid = a;
      a = b;
      b = mid;
    end
    if (!row_set[a] || !row_set[a + 1])
      return 1'b0;
    lo = row_tbl[a];
    hi = row_tbl[a + 1];
    if (hi > EDGE_SLOTS)
      hi = EDGE_SLOTS;
    if (lo >= hi)
      return 1'b1;
    for (int s = lo; s < hi; s++) begin
      if (!edge_set[s] || (s > lo && nb_tbl[s] <= nb_tbl[s - 1]))
        ok = 1'b0;
    end
    while (lo + 1 < hi) begin
      mid = lo + (hi - lo) / 2;
      if (nb_tbl[mid] > b)
        hi = mid;
      else
        lo = mid;
    end
    if (nb_tbl[lo] == b) begin
      res.hit = 1'b1;
      res.tag = tag_tbl[lo];
    end
    return ok;
  endfunction

  function automatic lookup_item_t noise_item();
    lookup_item_t it;
    it.op   = 2'($urandom_range(0, 3));
    it.idx  = 12'($urandom_range(0, 4095));
    it.offs = 13'($urandom_range(0, 8191));
    it.nb   = 10'($urandom_range(0, 1023));
    it.tag  = 12'($urandom_range(0, 4095));
    it.u    = 11'($urandom_range(0, 2047));
    it.w    = 11'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic lookup_item_t row_item(input int idx, input int off);
    lookup_item_t it;
    it = noise_item();
    it.op = cel_pkg::OP_ROW;
    it.idx = 12'(idx);
    it.offs = 13'(off);
    return it;
  endfunction

  function automatic lookup_item_t edge_item(input int idx, input int nb, input int tag);
    lookup_item_t it;
    it = noise_item();
    it.op = cel_pkg::OP_EDGE;
    it.idx = 12'(idx);
    it.nb = 10'(nb);
    it.tag = 12'(tag);
    return it;
  endfunction

  function automatic lookup_item_t pair_item(input int u, input int w);
    lookup_item_t it;
    it = noise_item();
    it.op = cel_pkg::OP_QUERY;
    it.u = 11'(u);
    it.w = 11'(w);
    return it;
  endfunction

  task automatic send_item(input lookup_item_t it);
    lookup_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= it.op;
    write_index <= it.idx;
    row_offset  <= it.offs;
    neighbor    <= it.nb;
    tag_in      <= it.tag;
    node_u      <= it.u;
    node_w      <= it.w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (it.op)
      cel_pkg::OP_ROW: begin
        if (it.idx <= NODE_SLOTS) begin
          row_tbl[it.idx] = it.offs;
          row_set[it.idx] = 1'b1;
        end
      end
      cel_pkg::OP_EDGE: begin
        nb_tbl[it.idx] = it.nb;
        tag_tbl[it.idx] = it.tag;
        edge_set[it.idx] = 1'b1;
      end
      cel_pkg::OP_QUERY: begin
        void'(lookup_pair(it.u, it.w, res));
        pending_lookups.insert(pending_lookups.size(), res);
      end
      default: ;
    endcase
    if (it.op != OP_UNUSED)
      items_sent++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_bound(input int value);
    wait_drained(8);
    cfg_valid <= 1'b1;
    cfg_data  <= 11'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_bound = 11'(value);
  endtask

  task automatic load_graph(input int first, input int rows, input int base, input int max_deg);
    int slot, v, deg;
    slot = base;
    for (int r = 0; r <= rows; r++) begin
      send_item(row_item(first + r,
                         (slot < EDGE_SLOTS) ? slot : $urandom_range(EDGE_SLOTS, 8191)));
      if (r < rows) begin
        deg = $urandom_range(0, max_deg);
        v = first + r + 1 + $urandom_range(0, 2);
        for (int k = 0; k < deg && v < NODE_SLOTS && slot < EDGE_SLOTS; k++) begin
          send_item(edge_item(slot, v, $urandom_range(0, 4095)));
          slot++;
          v += 1 + $urandom_range(0, 2);
        end
      end
    end
  endtask

  task automatic query_graph(input int first, input int rows, input int count);
    lookup_item_t it;
    lookup_result_t res;
    int u, w, lo, hi, roll, slot;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      u = first + $urandom_range(0, rows - 1);
      w = first + $urandom_range(0, rows + 3);
      lo = row_tbl[u];
      hi = (row_tbl[u + 1] > EDGE_SLOTS) ? EDGE_SLOTS : row_tbl[u + 1];
      slot = (lo < hi) ? lo + $urandom_range(0, hi - lo - 1) : 0;
      if (roll < 45)
        w = nb_tbl[slot];
      it = ($urandom_range(0, 1) == 1) ? pair_item(w, u) : pair_item(u, w);
      if (roll >= 75 && roll < 85) begin
        case ($urandom_range(0, 2))
          0: it.u[10] = 1'b1;
          1: it.w = 11'(node_bound + $urandom_range(0, 7));
          default: it.w = it.u;
        endcase
      end else if (roll >= 85 && roll < 93) begin
        it = noise_item();
        case ($urandom_range(0, 3))
          0: it.op = OP_UNUSED;
          1: begin
            it.op = cel_pkg::OP_ROW;
            it.idx = 12'($urandom_range(NODE_SLOTS + 1, 4095));
          end
          2: it = row_item(u + $urandom_range(0, 1), $urandom_range(0, 8191));
          default: begin
            if (edge_set[slot])
              it = edge_item(slot, nb_tbl[slot], $urandom_range(0, 4095));
            else
              it.op = OP_UNUSED;
          end
        endcase
      end else if (roll >= 93) begin
        it = noise_item();
        it.op = cel_pkg::OP_QUERY;
      end
      if (it.op != cel_pkg::OP_QUERY || lookup_pair(it.u, it.w, res))
        send_item(it);
    end
  endtask

  task automatic test_directed();
    lookup_item_t it;
    set_bound(5);
    send_item(row_item(0, 4092));
    send_item(row_item(1, 4094));
    send_item(row_item(2, 8191));
    send_item(row_item(3, 2));
    send_item(row_item(4, 2));
    send_item(edge_item(4092, 2, 4095));
    send_item(edge_item(4093, 4, 0));
    send_item(edge_item(4094, 2, 'h5A5));
    send_item(edge_item(4095, 1023, 'hA5A));
    // drop: slots past the row table
    send_item(row_item(2049, 0));
    send_item(row_item(4095, 0));
    it = noise_item();
    it.op = OP_UNUSED;
    send_item(it);
    send_item(pair_item(0, 2));
    send_item(pair_item(4, 0));
    send_item(pair_item(0, 3));
    send_item(pair_item(2, 1));
    send_item(pair_item(1, 4));
    send_item(pair_item(2, 3));
    send_item(pair_item(3, 4));
    send_item(pair_item(4, 4));
    send_item(pair_item(-1, 2));
    send_item(pair_item(1, -1024));
    send_item(pair_item(5, 0));
    send_item(pair_item(0, 1023));
    set_bound(0);
    send_item(pair_item(0, 1));
    set_bound(2047);
    send_item(pair_item(0, 4));
  endtask

  task automatic test_random_graphs(input int budget);
    int start, rows, first, base, deg;
    start = items_sent;
    while (items_sent - start < budget) begin
      rows = $urandom_range(2, 20);
      first = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NODE_SLOTS - rows) : 0;
      deg = $urandom_range(1, 5);
      base = ($urandom_range(0, 3) == 0) ? EDGE_SLOTS - $urandom_range(1, 2 * rows)
                                         : $urandom_range(0, 3000);
      case ($urandom_range(0, 7))
        0: set_bound($urandom_range(0, 2047));
        1: set_bound(first + rows);
        default: set_bound(first + rows + $urandom_range(1, 6));
      endcase
      load_graph(first, rows, base, deg);
      query_graph(first, rows, $urandom_range(20, 50));
    end
  endtask

  task automatic test_wide_bound();
    load_graph(NODE_SLOTS - 8, 8, $urandom_range(0, 4000), 4);
    set_bound(2047);
    query_graph(NODE_SLOTS - 8, 8, 60);
    set_bound(NODE_SLOTS);
    query_graph(NODE_SLOTS - 8, 8, 60);
    set_bound(NODE_SLOTS - 1);
    query_graph(NODE_SLOTS - 8, 8, 60);
  endtask

  task automatic test_drain_pause();
    set_bound(16);
    load_graph(0, 16, $urandom_range(0, 3000), 3);
    repeat (6) begin
      query_graph(0, 16, 10);
      wait_drained(0);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: found=%0d tag_out=%0d", found, tag_out);
      end else begin
        oldest = pending_lookups.pop_front();
        if (found !== oldest.hit || tag_out !== oldest.tag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lookup mismatch: expected found=%0d tag_out=%0d, got found=%0d tag_out=%0d",
                     oldest.hit, oldest.tag, found, tag_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 36;
    recv_stall_pct = 58;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_graphs(520);
    test_wide_bound();
    send_idle_pct = 58;
    recv_stall_pct = 36;
    test_random_graphs(520);
    test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_graphs(520);
    wait_drained(40);
    if (mismatches == 0 && pending_lookups.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cel_pkg.sv
rtl/cel_ram.sv
rtl/cel_step.sv
rtl/csr_edge_lookup.sv
bench/tb_csr_edge_lookup.sv
